@@ src/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle test package
// Coordinate widths, pipeline stage payload types and the small arithmetic
// helpers shared by the pipeline stages.
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_COORDS  = 12;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int SUM_W       = CROSS_W + 1;
    localparam int S_TDATA_W   = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;
    typedef logic        [CROSS_W-1:0]     mag_t;
    typedef logic signed [SUM_W-1:0]       sum_t;

    typedef struct packed {
        coord_t ax, ay, az;
        coord_t bx, by, bz;
        coord_t cx, cy, cz;
        coord_t px, py, pz;
    } point_set_t;

    // v0 = c - a, v1 = b - a, v2 = p - a
    typedef struct packed {
        diff_t v0x, v0y, v0z;
        diff_t v1x, v1y, v1z;
        diff_t v2x, v2y, v2z;
    } geom_t;

    typedef struct packed {
        prod_t pxa, pxb;
        prod_t pya, pyb;
        prod_t pza, pzb;
    } nprod_t;

    typedef struct packed {
        mag_t  nx, ny, nz;
        geom_t geom;
    } normal_t;

    typedef struct packed {
        diff_t v0s, v0t;
        diff_t v1s, v1t;
        diff_t v2s, v2t;
    } proj_t;

    typedef struct packed {
        prod_t ka, kb;
        prod_t x02a, x02b;
        prod_t x21a, x21b;
    } bprod_t;

    typedef struct packed {
        cross_t k;
        cross_t x02;
        cross_t x21;
    } bary_t;

    function automatic diff_t diff_f(input coord_t a, input coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

    function automatic prod_t mul_f(input diff_t a, input diff_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    function automatic cross_t sub_f(input prod_t a, input prod_t b);
        return cross_t'(a) - cross_t'(b);
    endfunction

    function automatic mag_t abs_f(input cross_t x);
        cross_t neg;
        neg = -x;
        return x[CROSS_W-1] ? mag_t'(neg) : mag_t'(x);
    endfunction

endpackage

@@ src/pit_normal.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle normal stages
// Three register stages: edge vectors from corner a, the six partial products
// of the normal, and the normal magnitudes per axis.
// ----------------------------------------------------------------------------
module pit_normal (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pit_pkg::point_set_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pit_pkg::normal_t    out_data
);
    import pit_pkg::*;

    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic    s1_ready, s2_ready, s3_ready;
    geom_t   s1_geom_reg, s1_geom_next;
    geom_t   s2_geom_reg;
    nprod_t  s2_prod_reg, s2_prod_next;
    normal_t s3_norm_reg, s3_norm_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        s1_geom_next.v0x = diff_f(in_data.cx, in_data.ax);
        s1_geom_next.v0y = diff_f(in_data.cy, in_data.ay);
        s1_geom_next.v0z = diff_f(in_data.cz, in_data.az);
        s1_geom_next.v1x = diff_f(in_data.bx, in_data.ax);
        s1_geom_next.v1y = diff_f(in_data.by, in_data.ay);
        s1_geom_next.v1z = diff_f(in_data.bz, in_data.az);
        s1_geom_next.v2x = diff_f(in_data.px, in_data.ax);
        s1_geom_next.v2y = diff_f(in_data.py, in_data.ay);
        s1_geom_next.v2z = diff_f(in_data.pz, in_data.az);
    end

    // The normal (a - c) x (b - c) equals (b - a) x (c - a).
    always_comb begin
        s2_prod_next.pxa = mul_f(s1_geom_reg.v1y, s1_geom_reg.v0z);
        s2_prod_next.pxb = mul_f(s1_geom_reg.v1z, s1_geom_reg.v0y);
        s2_prod_next.pya = mul_f(s1_geom_reg.v1z, s1_geom_reg.v0x);
        s2_prod_next.pyb = mul_f(s1_geom_reg.v1x, s1_geom_reg.v0z);
        s2_prod_next.pza = mul_f(s1_geom_reg.v1x, s1_geom_reg.v0y);
        s2_prod_next.pzb = mul_f(s1_geom_reg.v1y, s1_geom_reg.v0x);
    end

    always_comb begin
        s3_norm_next.nx   = abs_f(sub_f(s2_prod_reg.pxa, s2_prod_reg.pxb));
        s3_norm_next.ny   = abs_f(sub_f(s2_prod_reg.pya, s2_prod_reg.pyb));
        s3_norm_next.nz   = abs_f(sub_f(s2_prod_reg.pza, s2_prod_reg.pzb));
        s3_norm_next.geom = s2_geom_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_geom_reg <= s1_geom_next;
        end
        if (s2_ready) begin
            s2_geom_reg <= s1_geom_reg;
            s2_prod_reg <= s2_prod_next;
        end
        if (s3_ready) begin
            s3_norm_reg <= s3_norm_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_norm_reg;

endmodule

@@ src/pit_project.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle projection stages
// Three register stages: dominant axis drop, the six partial products of the
// 2D cross terms, and the cross terms k, v0 x v2 and v2 x v1.
// ----------------------------------------------------------------------------
module pit_project (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pit_pkg::normal_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pit_pkg::bary_t   out_data
);
    import pit_pkg::*;

    logic   s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic   s4_ready, s5_ready, s6_ready;
    logic   drop_x, drop_y;
    proj_t  s4_proj_reg, s4_proj_next;
    bprod_t s5_prod_reg, s5_prod_next;
    bary_t  s6_bary_reg, s6_bary_next;

    assign s6_ready = !s6_valid_reg || out_ready;
    assign s5_ready = !s5_valid_reg || s6_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    // Ties go to the later axis.
    assign drop_x = (in_data.nx > in_data.ny) && (in_data.nx > in_data.nz);
    assign drop_y = !drop_x && (in_data.ny > in_data.nz);

    always_comb begin
        if (drop_x) begin
            s4_proj_next.v0s = in_data.geom.v0y;
            s4_proj_next.v0t = in_data.geom.v0z;
            s4_proj_next.v1s = in_data.geom.v1y;
            s4_proj_next.v1t = in_data.geom.v1z;
            s4_proj_next.v2s = in_data.geom.v2y;
            s4_proj_next.v2t = in_data.geom.v2z;
        end else if (drop_y) begin
            s4_proj_next.v0s = in_data.geom.v0x;
            s4_proj_next.v0t = in_data.geom.v0z;
            s4_proj_next.v1s = in_data.geom.v1x;
            s4_proj_next.v1t = in_data.geom.v1z;
            s4_proj_next.v2s = in_data.geom.v2x;
            s4_proj_next.v2t = in_data.geom.v2z;
        end else begin
            s4_proj_next.v0s = in_data.geom.v0x;
            s4_proj_next.v0t = in_data.geom.v0y;
            s4_proj_next.v1s = in_data.geom.v1x;
            s4_proj_next.v1t = in_data.geom.v1y;
            s4_proj_next.v2s = in_data.geom.v2x;
            s4_proj_next.v2t = in_data.geom.v2y;
        end
    end

    always_comb begin
        s5_prod_next.ka   = mul_f(s4_proj_reg.v0s, s4_proj_reg.v1t);
        s5_prod_next.kb   = mul_f(s4_proj_reg.v0t, s4_proj_reg.v1s);
        s5_prod_next.x02a = mul_f(s4_proj_reg.v0s, s4_proj_reg.v2t);
        s5_prod_next.x02b = mul_f(s4_proj_reg.v0t, s4_proj_reg.v2s);
        s5_prod_next.x21a = mul_f(s4_proj_reg.v2s, s4_proj_reg.v1t);
        s5_prod_next.x21b = mul_f(s4_proj_reg.v2t, s4_proj_reg.v1s);
    end

    always_comb begin
        s6_bary_next.k   = sub_f(s5_prod_reg.ka, s5_prod_reg.kb);
        s6_bary_next.x02 = sub_f(s5_prod_reg.x02a, s5_prod_reg.x02b);
        s6_bary_next.x21 = sub_f(s5_prod_reg.x21a, s5_prod_reg.x21b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else begin
            if (s4_ready) begin
                s4_valid_reg <= in_valid;
            end
            if (s5_ready) begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (s6_ready) begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            s4_proj_reg <= s4_proj_next;
        end
        if (s5_ready) begin
            s5_prod_reg <= s5_prod_next;
        end
        if (s6_ready) begin
            s6_bary_reg <= s6_bary_next;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_bary_reg;

endmodule

@@ src/pit_decide.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle decision stage
// Sign tests on the cross terms, the far-edge bound and the output register
// of the result channel.
// ----------------------------------------------------------------------------
module pit_decide (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           quadrant_mode,
    input  logic           in_valid,
    output logic           in_ready,
    input  pit_pkg::bary_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           inside_res,
    output logic           degenerate
);
    import pit_pkg::*;

    logic out_valid_reg;
    logic inside_reg, inside_next;
    logic degen_reg, degen_next;
    logic k_neg, u_pos, v_pos, far_ok;
    sum_t uv_sum, k_ext;

    assign in_ready = !out_valid_reg || out_ready;

    assign k_neg  = in_data.k[CROSS_W-1];
    assign u_pos  = (in_data.x21 != '0) && (in_data.x21[CROSS_W-1] == k_neg);
    assign v_pos  = (in_data.x02 != '0) && (in_data.x02[CROSS_W-1] == k_neg);
    assign uv_sum = sum_t'(in_data.x21) + sum_t'(in_data.x02);
    assign k_ext  = sum_t'(in_data.k);
    assign far_ok = k_neg ? (uv_sum > k_ext) : (uv_sum < k_ext);

    always_comb begin
        degen_next  = (in_data.k == '0);
        inside_next = !degen_next && u_pos && v_pos && (quadrant_mode || far_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            inside_reg <= inside_next;
            degen_reg  <= degen_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;

endmodule

@@ src/point_in_triangle_test_core.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle test core
// Pipeline: seven register stages between the accepted input word and the
// result word on m_tvalid.
// Throughput: one word per cycle, since every stage takes a new word each cycle
// unless the stage after it is full and stalled.
// Reset: aresetn clears all valid bits and sets quadrant mode to 0.
// ----------------------------------------------------------------------------
module point_in_triangle_test_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_wdata,  // quadrant_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z,
    // corner_c_x, corner_c_y, corner_c_z, point_x, point_y, point_z
    input  logic [pit_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // inside_res, degenerate
    output logic [pit_pkg::M_TDATA_W-1:0] m_tdata
);
    import pit_pkg::*;

    logic       quadrant_mode_reg;
    point_set_t in_pts;
    normal_t    norm_data;
    bary_t      bary_data;
    logic       norm_valid, norm_ready;
    logic       bary_valid, bary_ready;
    logic       inside_res, degenerate;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quadrant_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            quadrant_mode_reg <= cfg_wdata[0];
        end
    end

    assign in_pts.ax = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.ay = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.az = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.bx = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.by = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.bz = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.cx = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.cy = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.cz = s_tdata[8*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.px = s_tdata[9*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.py = s_tdata[10*COORD_WIDTH +: COORD_WIDTH];
    assign in_pts.pz = s_tdata[11*COORD_WIDTH +: COORD_WIDTH];

    pit_normal u_normal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_pts),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    pit_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (bary_valid),
        .out_ready (bary_ready),
        .out_data  (bary_data)
    );

    pit_decide u_decide (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .quadrant_mode (quadrant_mode_reg),
        .in_valid      (bary_valid),
        .in_ready      (bary_ready),
        .in_data       (bary_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .inside_res    (inside_res),
        .degenerate    (degenerate)
    );

    assign m_tdata = {{(M_TDATA_W-2){1'b0}}, degenerate, inside_res};

endmodule

@@ src/pit_checker.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module pit_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pit_pkg::M_TDATA_W-1:0] m_tdata
);
    import pit_pkg::*;

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word valid right after reset.");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result word changed.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("Degenerate triangle reported inside.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:2] == '0))
        else $error("Result padding bits are not zero.");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while the result register is empty.");

endmodule

bind point_in_triangle_test_core pit_checker u_pit_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Point-in-triangle test core testbench
// Sends triangle and point words through the stream input. A local model of
// the projected barycentric test predicts each result word, and the monitor
// compares it field by field. The run covers both settings of quadrant mode,
// several patterns of sender gaps and receiver stalls, and two long receiver
// hold-offs that back the pipeline up into its input.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 231;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 12;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [0:0]           cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [S_TDATA_W-1:0] word_q[$];
    logic [1:0]           verdict_q[$];
    logic                 wedge_mode = 1'b0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_asked = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;
    int                   errors = 0;
    int                   results_seen = 0;
    int                   cycles = 0;

    point_in_triangle_test_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint magnitude(input longint x);
        return x < 0 ? -x : x;
    endfunction

    // Returns {degenerate, inside_res} for one word.
    function automatic logic [1:0] triangle_verdict(input logic [S_TDATA_W-1:0] w,
                                                    input logic wedge);
        longint a[3], b[3], c[3], p[3], e0[3], e1[3];
        longint nx, ny, nz, v0s, v0t, v1s, v1t, v2s, v2t, k, x02, x21, sum;
        int s, t, i;
        logic u_pos, v_pos, far_ok;
        for (i = 0; i < 3; i++) begin
            a[i] = longint'(coord_t'(w[COORD_WIDTH*i +: COORD_WIDTH]));
            b[i] = longint'(coord_t'(w[COORD_WIDTH*(3+i) +: COORD_WIDTH]));
            c[i] = longint'(coord_t'(w[COORD_WIDTH*(6+i) +: COORD_WIDTH]));
            p[i] = longint'(coord_t'(w[COORD_WIDTH*(9+i) +: COORD_WIDTH]));
            e0[i] = a[i] - c[i];
            e1[i] = b[i] - c[i];
        end
        nx = magnitude(e0[1] * e1[2] - e0[2] * e1[1]);
        ny = magnitude(e0[2] * e1[0] - e0[0] * e1[2]);
        nz = magnitude(e0[0] * e1[1] - e0[1] * e1[0]);
        if (nx > ny && nx > nz) begin
            s = 1; t = 2;
        end else if (ny > nz) begin
            s = 0; t = 2;
        end else begin
            s = 0; t = 1;
        end
        v0s = c[s] - a[s]; v0t = c[t] - a[t];
        v1s = b[s] - a[s]; v1t = b[t] - a[t];
        v2s = p[s] - a[s]; v2t = p[t] - a[t];
        k   = v0s * v1t - v0t * v1s;
        x02 = v0s * v2t - v0t * v2s;
        x21 = v2s * v1t - v2t * v1s;
        if (k == 0)
            return 2'b10;
        sum = x21 + x02;
        if (k > 0) begin
            u_pos = x21 > 0; v_pos = x02 > 0; far_ok = sum < k;
        end else begin
            u_pos = x21 < 0; v_pos = x02 < 0; far_ok = sum > k;
        end
        return {1'b0, u_pos && v_pos && (wedge || far_ok)};
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_coords(input longint v[12]);
        logic [S_TDATA_W-1:0] w;
        int i;
        w = '0;
        for (i = 0; i < 12; i++)
            w[COORD_WIDTH*i +: COORD_WIDTH] = v[i][COORD_WIDTH-1:0];
        return w;
    endfunction

    function automatic logic [S_TDATA_W-1:0] corners_word(
        input longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz);
        longint v[12];
        v = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
        return pack_coords(v);
    endfunction

    function automatic longint spread(input int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly well-formed geometry: points inside, in the wedge beyond the far
    // edge, exactly on an edge, and collinear triangles; the rest is raw noise.
    function automatic logic [S_TDATA_W-1:0] random_query();
        longint v[12], d[3];
        longint wa, wb, wc;
        int sel, span, i;
        sel = $urandom_range(99);
        case ($urandom_range(2))
            0: begin
                span = 20;
            end
            1: begin
                span = 300;
            end
            default: begin
                span = 8000;
            end
        endcase
        for (i = 0; i < 12; i++)
            v[i] = spread(span);
        if (sel < 30) begin
            for (i = 0; i < 12; i++)
                v[i] = longint'($urandom);
        end else if (sel < 65) begin
            wa = $urandom_range(8);
            wb = $urandom_range(8);
            wc = $urandom_range(1, 8);
            for (i = 0; i < 3; i++)
                v[9+i] = (wa * v[i] + wb * v[3+i] + wc * v[6+i]) / (wa + wb + wc);
        end else if (sel < 80) begin
            wb = $urandom_range(1, 6);
            wc = $urandom_range(1, 6);
            for (i = 0; i < 3; i++)
                v[9+i] = v[i] + ((v[3+i] - v[i]) * wb + (v[6+i] - v[i]) * wc) / 4;
        end else if (sel < 92) begin
            wb = longint'($urandom_range(8)) - 4;
            wc = longint'($urandom_range(8)) - 4;
            for (i = 0; i < 3; i++) begin
                d[i] = spread(span / 4 + 1);
                v[3+i] = v[i] + wb * d[i];
                v[6+i] = v[i] + wc * d[i];
            end
        end else begin
            for (i = 0; i < 3; i++) begin
                d[i] = spread(span);
                v[3+i] = v[i] + 2 * d[i];
                v[9+i] = v[i] + d[i];
            end
        end
        return pack_coords(v);
    endfunction

    task automatic note_mismatch(input string msg);
        if (errors < 40)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    task automatic drain();
        do begin
            while (word_q.size() != 0 || verdict_q.size() != 0 || s_tvalid)
                @(posedge aclk);
            repeat (SETTLE) @(posedge aclk);
        end while (word_q.size() != 0 || verdict_q.size() != 0 || s_tvalid);
    endtask

    task automatic set_wedge(input logic m);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        wedge_mode = m;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_word(input logic [S_TDATA_W-1:0] w);
        word_q.insert(word_q.size(), w);
    endtask

    task automatic queue_directed();
        // Right triangle in the xy plane: inside, beyond the far edge, on an
        // edge and on a corner, then the same triangle wound the other way.
        queue_word(corners_word(0, 0, 0, 300, 0, 0, 0, 300, 0, 50, 50, 0));
        queue_word(corners_word(0, 0, 0, 300, 0, 0, 0, 300, 0, 400, 400, 7));
        queue_word(corners_word(0, 0, 0, 300, 0, 0, 0, 300, 0, 150, 0, 0));
        queue_word(corners_word(0, 0, 0, 300, 0, 0, 0, 300, 0, 0, 0, 0));
        queue_word(corners_word(0, 0, 0, 0, 300, 0, 300, 0, 0, 50, 50, 0));
        // Collinear corners, three coincident corners, and a full-range triangle.
        queue_word(corners_word(0, 0, 0, 10, 10, 10, 20, 20, 20, 5, 5, 5));
        queue_word(corners_word(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, 32767, 32767, 32767));
        queue_word(corners_word(-32768, -32768, -32768, 32767, -32768, 32767,
                                -32768, 32767, 32767, 0, 0, 0));
        // Normal components tied three ways, then tied between x and y.
        queue_word(corners_word(1000, 0, 0, 0, 1000, 0, 0, 0, 1000, 333, 333, 333));
        queue_word(corners_word(1000, 0, 0, 0, 1000, 0, 1000, 0, 1000, 600, 400, 300));
        // Triangles facing along x and along y.
        queue_word(corners_word(5, 0, 0, 5, 100, 0, 5, 0, 100, -9, 10, 10));
        queue_word(corners_word(0, 7, 0, 100, 7, 0, 0, 7, 100, 10, 32767, 10));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q.insert(verdict_q.size(), triangle_verdict(s_tdata, wedge_mode));
            if (!s_tvalid || s_tready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= word_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge aclk) begin
        logic [1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    note_mismatch("word arrived with no prediction waiting");
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want[0])
                        note_mismatch($sformatf("inside_res got %b expected %b",
                                                m_tdata[0], want[0]));
                    if (m_tdata[1] !== want[1])
                        note_mismatch($sformatf("degenerate got %b expected %b",
                                                m_tdata[1], want[1]));
                end
                results_seen++;
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("point_in_triangle_test_core verification failed");
            $finish;
        end
    end

    initial begin
        int ph, n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            set_wedge(ph[0]);
            case (ph / 2)
                0: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 65; recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0; recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct = 13; recv_stall_pct = 13;
                end
            endcase
            if (ph < 2)
                queue_directed();
            for (n = 0; n < PHASE_WORDS; n++)
                queue_word(random_query());
            if (ph == 0 || ph == 3)
                hold_asked++;
        end
        drain();
        if (errors == 0) begin
            $display("point_in_triangle_test_core verification clean");
        end else begin
            $display("point_in_triangle_test_core verification failed");
        end
        $finish;
    end

endmodule
